>>> rtl/rth_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_pkg: shared widths, types and stage numbers for the ray/triangle tester
// Every internal width is derived from the coordinate and bound widths so
// that each intermediate product and sum is held exactly.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Coordinate format of the packed input vectors.
  localparam int COORD_BITS = 21;
  localparam int FRAC_BITS  = 10;
  localparam int PACK_W     = 63;
  localparam int MAX_W      = 20;

  // Edge and offset vectors carry one extra bit over a coordinate.
  localparam int DW     = COORD_BITS + 1;
  // Cross products (normal and q), both held at this width.
  localparam int NW     = 2 * DW + 1;
  // Split of a cross product component for the dot product multipliers.
  localparam int LO_W   = (NW + 1) / 2;
  localparam int HI_W   = NW - LO_W;
  localparam int PL_W   = LO_W + 1 + DW;
  localparam int PH_W   = HI_W + DW;
  // Dot products: a cross component times a vector component, three terms.
  localparam int DOT_W  = NW + DW + 2;
  localparam int SUM_W  = DOT_W + 1;
  // Split of the determinant for the distance bound multiply.
  localparam int R_LO_W = DOT_W / 2;
  localparam int R_HI_W = DOT_W - R_LO_W;
  localparam int RPL_W  = R_LO_W + 1 + MAX_W + 1;
  localparam int RPH_W  = R_HI_W + MAX_W + 1;
  localparam int CMP_W  = DOT_W + MAX_W + 1;

  // Pipeline stage numbers.
  localparam int NUM_STAGES = 6;
  localparam int ST_PREP    = 0;
  localparam int ST_CROSS   = 1;
  localparam int ST_PART    = 2;
  localparam int ST_SUM     = 3;
  localparam int ST_FLAG    = 4;
  localparam int ST_OUT     = 5;

  // Dot product slots.
  localparam int NUM_DOTS = 4;
  localparam int DOT_R    = 0;  // determinant, direction . normal
  localparam int DOT_U    = 1;  // q . b
  localparam int DOT_V    = 2;  // q . a
  localparam int DOT_T    = 3;  // normal . p

  typedef logic [PACK_W-1:0]            pack_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         dval_t;
  typedef logic signed [NW-1:0]         nval_t;
  typedef logic signed [PL_W-1:0]       pl_t;
  typedef logic signed [PH_W-1:0]       ph_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [RPL_W-1:0]      rpl_t;
  typedef logic signed [RPH_W-1:0]      rph_t;
  typedef logic signed [CMP_W-1:0]      cmp_t;
  typedef logic [MAX_W-1:0]             rmax_t;

endpackage
`default_nettype wire

>>> rtl/rth_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_prep: unpack and difference stage
// Unpacks the coordinate triples and registers a = v0-v1, b = v2-v0,
// p = v0-origin, the sign-extended direction and the distance bound.
// ----------------------------------------------------------------------------
module rth_prep (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire rth_pkg::pack_t ray_origin_i,
  input  wire rth_pkg::pack_t ray_direction_i,
  input  wire rth_pkg::pack_t vertex_zero_i,
  input  wire rth_pkg::pack_t vertex_one_i,
  input  wire rth_pkg::pack_t vertex_two_i,
  input  wire rth_pkg::rmax_t ray_max_i,
  output rth_pkg::dval_t      a_o   [3],
  output rth_pkg::dval_t      b_o   [3],
  output rth_pkg::dval_t      p_o   [3],
  output rth_pkg::dval_t      dir_o [3],
  output rth_pkg::rmax_t      rmax_o
);

  rth_pkg::dval_t a_d [3], b_d [3], p_d [3], dir_d [3];
  rth_pkg::dval_t a_q [3], b_q [3], p_q [3], dir_q [3];
  rth_pkg::rmax_t rmax_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i]   = rth_pkg::dval_t'(
                   rth_pkg::coord_t'(vertex_zero_i[i*rth_pkg::COORD_BITS +: rth_pkg::COORD_BITS]))
               - rth_pkg::dval_t'(
                   rth_pkg::coord_t'(vertex_one_i[i*rth_pkg::COORD_BITS +: rth_pkg::COORD_BITS]));
      b_d[i]   = rth_pkg::dval_t'(
                   rth_pkg::coord_t'(vertex_two_i[i*rth_pkg::COORD_BITS +: rth_pkg::COORD_BITS]))
               - rth_pkg::dval_t'(
                   rth_pkg::coord_t'(vertex_zero_i[i*rth_pkg::COORD_BITS +: rth_pkg::COORD_BITS]));
      p_d[i]   = rth_pkg::dval_t'(
                   rth_pkg::coord_t'(vertex_zero_i[i*rth_pkg::COORD_BITS +: rth_pkg::COORD_BITS]))
               - rth_pkg::dval_t'(
                   rth_pkg::coord_t'(ray_origin_i[i*rth_pkg::COORD_BITS +: rth_pkg::COORD_BITS]));
      dir_d[i] = rth_pkg::dval_t'(
                   rth_pkg::coord_t'(ray_direction_i[i*rth_pkg::COORD_BITS +: rth_pkg::COORD_BITS]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      p_q    <= p_d;
      dir_q  <= dir_d;
      rmax_q <= ray_max_i;
    end
  end

  assign a_o    = a_q;
  assign b_o    = b_q;
  assign p_o    = p_q;
  assign dir_o  = dir_q;
  assign rmax_o = rmax_q;

endmodule
`default_nettype wire

>>> rtl/rth_cross.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_cross: cross product stage
// Registers the normal n = b x a and q = p x direction, and carries the
// edge, offset and direction vectors along for the dot products.
// ----------------------------------------------------------------------------
module rth_cross (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire rth_pkg::dval_t a_i   [3],
  input  wire rth_pkg::dval_t b_i   [3],
  input  wire rth_pkg::dval_t p_i   [3],
  input  wire rth_pkg::dval_t dir_i [3],
  input  wire rth_pkg::rmax_t rmax_i,
  output rth_pkg::nval_t      n_o   [3],
  output rth_pkg::nval_t      q_o   [3],
  output rth_pkg::dval_t      a_o   [3],
  output rth_pkg::dval_t      b_o   [3],
  output rth_pkg::dval_t      p_o   [3],
  output rth_pkg::dval_t      dir_o [3],
  output rth_pkg::rmax_t      rmax_o
);

  // Returns w*x - y*z at the cross product width.
  function automatic rth_pkg::nval_t cross_term(input rth_pkg::dval_t w, input rth_pkg::dval_t x,
                                                input rth_pkg::dval_t y, input rth_pkg::dval_t z);
    logic signed [2*rth_pkg::DW-1:0] m0, m1;
    m0 = w * x;
    m1 = y * z;
    return rth_pkg::nval_t'(m0) - rth_pkg::nval_t'(m1);
  endfunction

  rth_pkg::nval_t n_d [3], q_d [3], n_q [3], q_q [3];
  rth_pkg::dval_t a_q [3], b_q [3], p_q [3], dir_q [3];
  rth_pkg::rmax_t rmax_q;

  always_comb begin
    n_d[0] = cross_term(b_i[1], a_i[2], b_i[2], a_i[1]);
    n_d[1] = cross_term(b_i[2], a_i[0], b_i[0], a_i[2]);
    n_d[2] = cross_term(b_i[0], a_i[1], b_i[1], a_i[0]);
    q_d[0] = cross_term(p_i[1], dir_i[2], p_i[2], dir_i[1]);
    q_d[1] = cross_term(p_i[2], dir_i[0], p_i[0], dir_i[2]);
    q_d[2] = cross_term(p_i[0], dir_i[1], p_i[1], dir_i[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      q_q    <= q_d;
      a_q    <= a_i;
      b_q    <= b_i;
      p_q    <= p_i;
      dir_q  <= dir_i;
      rmax_q <= rmax_i;
    end
  end

  assign n_o    = n_q;
  assign q_o    = q_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign p_o    = p_q;
  assign dir_o  = dir_q;
  assign rmax_o = rmax_q;

endmodule
`default_nettype wire

>>> rtl/rth_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_dot: dot product stages
// The first stage multiplies each cross component, split into a low unsigned
// half and a high signed half, by its vector component. The second stage
// recombines the halves and sums the three terms of each dot product.
// ----------------------------------------------------------------------------
module rth_dot (
  input  wire logic           clk_i,
  input  wire logic           part_en_i,
  input  wire logic           sum_en_i,
  input  wire rth_pkg::nval_t n_i   [3],
  input  wire rth_pkg::nval_t q_i   [3],
  input  wire rth_pkg::dval_t a_i   [3],
  input  wire rth_pkg::dval_t b_i   [3],
  input  wire rth_pkg::dval_t p_i   [3],
  input  wire rth_pkg::dval_t dir_i [3],
  input  wire rth_pkg::rmax_t rmax_i,
  output rth_pkg::dot_t       dot_o [rth_pkg::NUM_DOTS],
  output rth_pkg::rmax_t      rmax_o
);

  rth_pkg::nval_t wide_op   [rth_pkg::NUM_DOTS][3];
  rth_pkg::dval_t narrow_op [rth_pkg::NUM_DOTS][3];
  rth_pkg::pl_t   pl_d [rth_pkg::NUM_DOTS][3], pl_q [rth_pkg::NUM_DOTS][3];
  rth_pkg::ph_t   ph_d [rth_pkg::NUM_DOTS][3], ph_q [rth_pkg::NUM_DOTS][3];
  rth_pkg::dot_t  dot_d [rth_pkg::NUM_DOTS], dot_q [rth_pkg::NUM_DOTS];
  rth_pkg::rmax_t rmax_part_q, rmax_sum_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide_op[rth_pkg::DOT_R][i]   = n_i[i];
      narrow_op[rth_pkg::DOT_R][i] = dir_i[i];
      wide_op[rth_pkg::DOT_U][i]   = q_i[i];
      narrow_op[rth_pkg::DOT_U][i] = b_i[i];
      wide_op[rth_pkg::DOT_V][i]   = q_i[i];
      narrow_op[rth_pkg::DOT_V][i] = a_i[i];
      wide_op[rth_pkg::DOT_T][i]   = n_i[i];
      narrow_op[rth_pkg::DOT_T][i] = p_i[i];
    end
  end

  always_comb begin
    logic signed [rth_pkg::LO_W:0]   lo_s;
    logic signed [rth_pkg::HI_W-1:0] hi_s;
    for (int k = 0; k < rth_pkg::NUM_DOTS; k++) begin
      for (int i = 0; i < 3; i++) begin
        lo_s       = {1'b0, wide_op[k][i][rth_pkg::LO_W-1:0]};
        hi_s       = wide_op[k][i][rth_pkg::NW-1:rth_pkg::LO_W];
        pl_d[k][i] = lo_s * narrow_op[k][i];
        ph_d[k][i] = hi_s * narrow_op[k][i];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < rth_pkg::NUM_DOTS; k++) begin
      dot_d[k] = '0;
      for (int i = 0; i < 3; i++) begin
        dot_d[k] = dot_d[k]
                 + (rth_pkg::dot_t'(ph_q[k][i]) <<< rth_pkg::LO_W)
                 + rth_pkg::dot_t'(pl_q[k][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (part_en_i) begin
      pl_q        <= pl_d;
      ph_q        <= ph_d;
      rmax_part_q <= rmax_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      dot_q      <= dot_d;
      rmax_sum_q <= rmax_part_q;
    end
  end

  assign dot_o  = dot_q;
  assign rmax_o = rmax_sum_q;

endmodule
`default_nettype wire

>>> rtl/rth_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_decide: sign folding, bound multiply and final compare
// The first stage folds the determinant's sign into the barycentric and
// distance tests and starts r * ray_max in two halves. The second stage
// completes the product and compares it against t shifted by the fraction.
// ----------------------------------------------------------------------------
module rth_decide (
  input  wire logic           clk_i,
  input  wire logic           flag_en_i,
  input  wire logic           out_en_i,
  input  wire rth_pkg::dot_t  dot_i [rth_pkg::NUM_DOTS],
  input  wire rth_pkg::rmax_t rmax_i,
  output logic                hit_o
);

  rth_pkg::dot_t r, un, vn, tn;
  rth_pkg::sum_t uv_sum, r_ext;
  logic          r_neg, r_zero, u_bad, v_bad, sum_bad, t_bad, miss_d;
  logic signed [rth_pkg::R_LO_W:0]   r_lo;
  logic signed [rth_pkg::R_HI_W-1:0] r_hi;
  logic signed [rth_pkg::MAX_W:0]    rmax_s;
  rth_pkg::rpl_t rpl_d, rpl_q;
  rth_pkg::rph_t rph_d, rph_q;
  rth_pkg::dot_t tn_q;
  logic          miss_q, r_neg_q, hit_d, hit_q;
  rth_pkg::cmp_t prod, lhs;

  always_comb begin
    r       = dot_i[rth_pkg::DOT_R];
    un      = dot_i[rth_pkg::DOT_U];
    vn      = dot_i[rth_pkg::DOT_V];
    tn      = dot_i[rth_pkg::DOT_T];
    r_neg   = r[rth_pkg::DOT_W-1];
    r_zero  = (r == '0);
    uv_sum  = rth_pkg::sum_t'(un) + rth_pkg::sum_t'(vn);
    r_ext   = rth_pkg::sum_t'(r);
    // With a negative determinant every inequality turns around.
    u_bad   = r_neg ? (un > 0) : un[rth_pkg::DOT_W-1];
    v_bad   = r_neg ? (vn > 0) : vn[rth_pkg::DOT_W-1];
    sum_bad = r_neg ? (uv_sum < r_ext) : (r_ext < uv_sum);
    t_bad   = r_neg ? (tn >= 0) : (tn <= 0);
    miss_d  = r_zero | u_bad | v_bad | sum_bad | t_bad;
    r_lo    = {1'b0, r[rth_pkg::R_LO_W-1:0]};
    r_hi    = r[rth_pkg::DOT_W-1:rth_pkg::R_LO_W];
    rmax_s  = {1'b0, rmax_i};
    rpl_d   = r_lo * rmax_s;
    rph_d   = r_hi * rmax_s;
  end

  always_ff @(posedge clk_i) begin
    if (flag_en_i) begin
      miss_q  <= miss_d;
      r_neg_q <= r_neg;
      tn_q    <= tn;
      rpl_q   <= rpl_d;
      rph_q   <= rph_d;
    end
  end

  always_comb begin
    prod  = (rth_pkg::cmp_t'(rph_q) <<< rth_pkg::R_LO_W) + rth_pkg::cmp_t'(rpl_q);
    lhs   = rth_pkg::cmp_t'(tn_q) <<< rth_pkg::FRAC_BITS;
    hit_d = !miss_q && (r_neg_q ? (lhs > prod) : (lhs < prod));
  end

  always_ff @(posedge clk_i) begin
    if (out_en_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule
`default_nettype wire

>>> rtl/ray_triangle_hit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_hit_test: pipelined, division-free ray/triangle intersection
// Tests one ray against one triangle per beat with exact fixed-point
// arithmetic and reports hit when the ray strikes strictly inside the
// distance bound, edges and corners counting as inside.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------
//  input   | in_valid_i / in_stall_o  | ray_origin_i, ray_direction_i,
//          |                          | vertex_zero_i/one_i/two_i, ray_max_i
//  output  | out_valid_o / out_stall_i| hit_o
//
// Throughput is one beat per cycle while out_stall_i is low; an accepted input
// beat passes through six register stages (unpack, cross products, split dot
// product multiplies, dot product sums, sign fold with the bound multiply,
// final compare) on the way to its result beat.
// Reset clears only the per-stage valid bits; data registers are not reset.
// Each stage holds while it is full and the stage after it holds, so bubbles
// close up behind a stalled result and new beats keep entering until the
// whole pipeline is full.
// ----------------------------------------------------------------------------
module ray_triangle_hit_test (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rth_pkg::pack_t ray_origin_i,
  input  wire rth_pkg::pack_t ray_direction_i,
  input  wire rth_pkg::pack_t vertex_zero_i,
  input  wire rth_pkg::pack_t vertex_one_i,
  input  wire rth_pkg::pack_t vertex_two_i,
  input  wire rth_pkg::rmax_t ray_max_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                hit_o
);

  // One valid bit and one load enable per register stage.
  logic [rth_pkg::NUM_STAGES-1:0] valid_q;
  logic [rth_pkg::NUM_STAGES-1:0] stage_en;
  logic in_acc, out_acc;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    stage_en[rth_pkg::NUM_STAGES-1] = !valid_q[rth_pkg::NUM_STAGES-1] || !out_stall_i;
    for (int k = rth_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < rth_pkg::NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !stage_en[0];
  assign out_valid_o = valid_q[rth_pkg::NUM_STAGES-1];
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Datapath between the stages.
  rth_pkg::dval_t s1_a [3], s1_b [3], s1_p [3], s1_dir [3];
  rth_pkg::rmax_t s1_rmax;
  rth_pkg::nval_t s2_n [3], s2_q [3];
  rth_pkg::dval_t s2_a [3], s2_b [3], s2_p [3], s2_dir [3];
  rth_pkg::rmax_t s2_rmax;
  rth_pkg::dot_t  s4_dot [rth_pkg::NUM_DOTS];
  rth_pkg::rmax_t s4_rmax;

  rth_prep u_prep (
    .clk_i           (clk_i),
    .en_i            (stage_en[rth_pkg::ST_PREP]),
    .ray_origin_i    (ray_origin_i),
    .ray_direction_i (ray_direction_i),
    .vertex_zero_i   (vertex_zero_i),
    .vertex_one_i    (vertex_one_i),
    .vertex_two_i    (vertex_two_i),
    .ray_max_i       (ray_max_i),
    .a_o             (s1_a),
    .b_o             (s1_b),
    .p_o             (s1_p),
    .dir_o           (s1_dir),
    .rmax_o          (s1_rmax)
  );

  rth_cross u_cross (
    .clk_i  (clk_i),
    .en_i   (stage_en[rth_pkg::ST_CROSS]),
    .a_i    (s1_a),
    .b_i    (s1_b),
    .p_i    (s1_p),
    .dir_i  (s1_dir),
    .rmax_i (s1_rmax),
    .n_o    (s2_n),
    .q_o    (s2_q),
    .a_o    (s2_a),
    .b_o    (s2_b),
    .p_o    (s2_p),
    .dir_o  (s2_dir),
    .rmax_o (s2_rmax)
  );

  rth_dot u_dot (
    .clk_i     (clk_i),
    .part_en_i (stage_en[rth_pkg::ST_PART]),
    .sum_en_i  (stage_en[rth_pkg::ST_SUM]),
    .n_i       (s2_n),
    .q_i       (s2_q),
    .a_i       (s2_a),
    .b_i       (s2_b),
    .p_i       (s2_p),
    .dir_i     (s2_dir),
    .rmax_i    (s2_rmax),
    .dot_o     (s4_dot),
    .rmax_o    (s4_rmax)
  );

  rth_decide u_decide (
    .clk_i     (clk_i),
    .flag_en_i (stage_en[rth_pkg::ST_FLAG]),
    .out_en_i  (stage_en[rth_pkg::ST_OUT]),
    .dot_i     (s4_dot),
    .rmax_i    (s4_rmax),
    .hit_o     (hit_o)
  );

  // The input side only stalls when every stage holds a beat.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while the pipeline has a free stage");

  // Beats in flight change only by accepted input and delivered output beats.
  a_beat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(valid_q) == $countones($past(valid_q))
              + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("a beat was lost or duplicated in the pipeline");

  // A result appears only after the stage before the output held a beat.
  a_out_from_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[rth_pkg::NUM_STAGES-2]))
    else $error("result beat appeared without a beat in the previous stage");

endmodule
`default_nettype wire
